// ===== rtl/core/dq_pkg.sv =====
// Shared constants, codes and control types for the double-ended queue.
package dq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_REAR  = 3'd5
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } stat_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic exec;
    logic load_out;
  } dq_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic out_held;
  } dq_sts_t;

endpackage

// ===== rtl/core/dq_ram.sv =====
// Generic simple dual-port RAM with registered read.
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/dq_ctrl.sv =====
// Sequencing state machine: accept, execute, respond.
module dq_ctrl
  import dq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    out_stall,
  input  dq_sts_t sts,
  output logic    in_stall,
  output dq_ctl_t ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_stall     = 1'b1;
    ctl          = '0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        // hold until the output register is free or its transfer completes now
        if (!sts.out_held || !out_stall) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/dq_dp.sv =====
// Ring pointers, entry count, entry store and output register.
module dq_dp
  import dq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  dq_ctl_t                  ctl,
  input  logic [CMD_W-1:0]         command,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     out_stall,
  output dq_sts_t                  sts,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] data,
  output logic [STAT_W-1:0]        status,
  output logic [OCC_W-1:0]         occupancy
);

  cmd_e              cmd_q;
  logic [DATA_W-1:0] val_q;
  logic [PTR_W-1:0]  head, head_next;
  logic [CNT_W-1:0]  count, count_next;
  stat_e             stat_q, stat_next;
  logic              use_ram, use_ram_next;

  logic              full, empty;
  logic [SUM_W-1:0]  sum, sum_m1;
  logic [PTR_W-1:0]  head_prev, tail_free, tail_last;
  logic              we, re;
  logic [PTR_W-1:0]  waddr, raddr;
  logic [DATA_W-1:0] rdata;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign sum    = SUM_W'(head) + SUM_W'(count);
  assign sum_m1 = sum - SUM_W'(1);

  // both sums stay below twice the depth: one compare and subtract wraps them
  always_comb begin
    logic [SUM_W-1:0] a, b;
    a = (sum >= SUM_W'(DEPTH)) ? sum - SUM_W'(DEPTH) : sum;
    b = (sum_m1 >= SUM_W'(DEPTH)) ? sum_m1 - SUM_W'(DEPTH) : sum_m1;
    tail_free = a[PTR_W-1:0];
    tail_last = b[PTR_W-1:0];
    head_prev = (head == '0) ? PTR_W'(DEPTH - 1) : head - PTR_W'(1);
  end

  always_comb begin
    head_next    = head;
    count_next   = count;
    stat_next    = STAT_OK;
    use_ram_next = 1'b0;
    we           = 1'b0;
    re           = 1'b0;
    waddr        = tail_free;
    raddr        = head;
    unique case (cmd_q)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (full) begin
          stat_next = STAT_FULL;
        end else begin
          we         = ctl.exec;
          count_next = count + CNT_W'(1);
          if (cmd_q == CMD_PUSH_FRONT) begin
            waddr     = head_prev;
            head_next = head_prev;
          end
        end
      end
      CMD_POP_FRONT, CMD_PEEK_FRONT: begin
        if (empty) begin
          stat_next = STAT_EMPTY;
        end else begin
          re           = ctl.exec;
          use_ram_next = 1'b1;
          if (cmd_q == CMD_POP_FRONT) begin
            head_next  = (head == PTR_W'(DEPTH - 1)) ? '0 : head + PTR_W'(1);
            count_next = count - CNT_W'(1);
          end
        end
      end
      CMD_POP_REAR, CMD_PEEK_REAR: begin
        if (empty) begin
          stat_next = STAT_EMPTY;
        end else begin
          re           = ctl.exec;
          use_ram_next = 1'b1;
          raddr        = tail_last;
          if (cmd_q == CMD_POP_REAR) begin
            count_next = count - CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  dq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(val_q),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.exec) begin
        head  <= head_next;
        count <= count_next;
      end
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_q <= cmd_e'(command);
      val_q <= value;
    end
    if (ctl.exec) begin
      stat_q  <= stat_next;
      use_ram <= use_ram_next;
    end
    if (ctl.load_out) begin
      data      <= use_ram ? rdata : '0;
      status    <= stat_q;
      occupancy <= OCC_W'(count);
    end
  end

  assign sts.out_held = out_valid;

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// Top level of the double-ended queue: controller plus datapath.
// A double-ended queue of up to DEPTH (16) signed 32-bit entries, held in a
// ring with a front pointer and a count. Each input transfer carries one
// command (push front, push rear, pop front, pop rear, peek front, peek rear)
// and produces exactly one result transfer with the popped or peeked data,
// a status (ok, empty on pop or peek, full on push) and the occupancy after
// the command. A push into a full queue is dropped; pop or peek on an empty
// queue returns data 0. Unused command codes do nothing and report ok.
// Each command is captured, then executes (pointer update and entry RAM
// access), then responds (the RAM's registered read data goes to the output
// register). A new command is taken only once the last has responded; a
// result waiting in the output register does not block the next command,
// but that command waits to respond until the output register is free.
// Reset clears the pointers and count at once; the entry store needs no
// clearing since only held entries are ever read.
module double_ended_queue
  import dq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         command,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] data,
  output logic [STAT_W-1:0]        status,
  output logic [OCC_W-1:0]         occupancy
);

  dq_ctl_t ctl;
  dq_sts_t sts;

  dq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .in_stall (in_stall),
    .ctl      (ctl)
  );

  dq_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .command  (command),
    .value    (value),
    .out_stall(out_stall),
    .sts      (sts),
    .out_valid(out_valid),
    .data     (data),
    .status   (status),
    .occupancy(occupancy)
  );

endmodule

// ===== rtl/core/dq_checker.sv =====
// Port-level checks for the double-ended queue, bound to the top level.
module dq_checker
  import dq_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DATA_W-1:0] data,
  input logic [STAT_W-1:0]        status,
  input logic [OCC_W-1:0]         occupancy
);

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> occupancy <= OCC_W'(DEPTH))
    else $error("occupancy above depth");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_FULL |-> occupancy == OCC_W'(DEPTH) && data == '0)
    else $error("full status without a full queue");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_EMPTY |-> occupancy == '0 && data == '0)
    else $error("empty status without an empty queue");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == STAT_OK || status == STAT_EMPTY || status == STAT_FULL)
    else $error("status code out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data) && $stable(status)
      && $stable(occupancy))
    else $error("stalled result changed");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .data     (data),
  .status   (status),
  .occupancy(occupancy)
);
